// ===== design/mtcqf_pkg.sv =====
// Shared types, codes and constants for the MIDI time code quarter-frame decoder.
package mtcqf_pkg;

	// MIDI status codes
	localparam logic [7:0] ST_QUARTER_FRAME = 8'hF1;
	localparam logic [7:0] ST_REALTIME_MIN  = 8'hF8;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 17;
	localparam logic [CFG_IDX_W-1:0] REG_US_PER_FRAME = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRU_ENABLE  = 4'd1;
	localparam logic [16:0] US_PER_FRAME_RESET = 17'd41667;

	// Rate type codes
	localparam logic [1:0] RATE_24 = 2'd0;
	localparam logic [1:0] RATE_25 = 2'd1;

	localparam logic [4:0] FPS_24 = 5'd24;
	localparam logic [4:0] FPS_25 = 5'd25;
	localparam logic [4:0] FPS_30 = 5'd30;

	localparam logic [5:0] SIXTY     = 6'd60;
	localparam logic [9:0] MS_PER_S  = 10'd1000;
	// ceil(2^32 / 1000); exact quotient for products below 6e6
	localparam logic [22:0] RECIP_1000 = 23'd4294968;

	localparam logic [7:0] ALL_PIECES = 8'hFF;
	localparam logic [2:0] PIECE_LAST = 3'd7;

	typedef struct packed {
		logic [7:0]  msg_status;
		logic [7:0]  msg_data1;
		logic [7:0]  msg_data2;
		logic [31:0] now_ms;
	} mtc_item_t;

	typedef struct packed {
		logic        rec_valid;
		logic [23:0] rec_message;
		logic [31:0] rec_time;
		logic        thru_valid;
	} mtc_result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LOCK1,
		S_LOCK2,
		S_LOCK3,
		S_DIV_LOAD,
		S_DIV_RUN,
		S_PART_MUL,
		S_PART_DIV,
		S_TIME_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic lock1;
		logic lock2;
		logic lock3;
		logic div_load;
		logic div_step;
		logic part_mul;
		logic part_div;
		logic time_sum;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic lock_now;
		logic rec_chan;
		logic div_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [4:0] fps_of_rate(input logic [1:0] rt);
		logic [4:0] fps;
		unique case (rt)
			RATE_24: fps = FPS_24;
			RATE_25: fps = FPS_25;
			default: fps = FPS_30;
		endcase
		return fps;
	endfunction

endpackage

// ===== design/mtcqf_ctrl.sv =====
// Sequencer for decode, lock conversion, time code division and result hand-off.
module mtcqf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mtcqf_pkg::dp_sts_t sts,
	output mtcqf_pkg::dp_cmd_t cmd
);
	import mtcqf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
				if (item_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.lock_now) begin
					state_d = S_LOCK1;
				end else if (sts.rec_chan) begin
					state_d = S_DIV_LOAD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_LOCK1: begin
				cmd.lock1 = 1'b1;
				state_d   = S_LOCK2;
			end
			S_LOCK2: begin
				cmd.lock2 = 1'b1;
				state_d   = S_LOCK3;
			end
			S_LOCK3: begin
				cmd.lock3 = 1'b1;
				state_d   = S_DIV_LOAD;
			end
			S_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV_RUN;
			end
			S_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_PART_MUL;
				end
			end
			S_PART_MUL: begin
				cmd.part_mul = 1'b1;
				state_d      = S_PART_DIV;
			end
			S_PART_DIV: begin
				cmd.part_div = 1'b1;
				state_d      = S_TIME_SUM;
			end
			S_TIME_SUM: begin
				cmd.time_sum = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// wait for the output register to free up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/mtcqf_datapath.sv =====
// Time code state, lock arithmetic, frame divider, time stamp adder and output register.
module mtcqf_datapath #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mtcqf_pkg::dp_cmd_t                  cmd,
	output mtcqf_pkg::dp_sts_t                  sts,
	input  mtcqf_pkg::mtc_item_t                item,
	output mtcqf_pkg::mtc_result_t              result,
	output logic                                result_valid,
	input  logic                                result_ready,
	input  logic                                cfg_valid,
	input  logic [mtcqf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mtcqf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mtcqf_pkg::*;

	// configuration
	logic [16:0] us_per_frame_q;
	logic        thru_enable_q;

	// time code state
	logic                 locked_q;
	logic [7:0]           pieces_q;
	logic [7:0]           start_frame_q;
	logic [7:0]           start_second_q;
	logic [7:0]           start_minute_q;
	logic [4:0]           start_hour_q;
	logic [1:0]           rate_q;
	logic [31:0]          frame_count_q;
	logic [TIME_BITS-1:0] last_frame_time_q;

	// per-item working registers
	mtc_item_t            item_q;
	logic                 rec_chan_q;
	logic                 mark_q;
	logic                 thru_q;
	logic [16:0]          acc_q;
	logic [31:0]          div_q;
	logic [4:0]           div_rem_q;
	logic [4:0]           div_cnt_q;
	logic [21:0]          prod_q;
	logic [41:0]          whole_q;
	logic [12:0]          part_q;
	logic [TIME_BITS-1:0] time_q;

	mtc_result_t          result_q;
	logic                 result_valid_q;

	logic [2:0]           piece;
	logic [3:0]           nib;
	logic [7:0]           seen_next;
	logic                 is_qf;
	logic                 is_other;
	logic [4:0]           fps;
	logic [5:0]           trial;
	logic                 trial_ge;
	logic [44:0]          recip_prod;
	logic [TIME_BITS-1:0] elapsed;

	assign piece     = item_q.msg_data1[6:4];
	assign nib       = item_q.msg_data1[3:0];
	assign seen_next = pieces_q | (8'b1 << piece);
	assign is_qf     = (item_q.msg_status == ST_QUARTER_FRAME);
	assign is_other  = !is_qf && (item_q.msg_status < ST_REALTIME_MIN);
	assign fps       = fps_of_rate(rate_q);

	assign trial      = {div_rem_q, div_q[31]};
	assign trial_ge   = (trial >= {1'b0, fps});
	assign recip_prod = 45'(prod_q) * 45'(RECIP_1000);
	assign elapsed    = TIME_BITS'(item_q.now_ms) - last_frame_time_q;

	assign sts.lock_now = is_qf && !locked_q && (piece == PIECE_LAST)
		&& (seen_next == ALL_PIECES);
	assign sts.rec_chan = is_other && locked_q;
	assign sts.div_last = (div_cnt_q == 5'd31);
	assign sts.out_free = !result_valid_q || result_ready;

	assign result       = result_q;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_per_frame_q <= US_PER_FRAME_RESET;
			thru_enable_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_US_PER_FRAME: us_per_frame_q <= cfg_data;
				REG_THRU_ENABLE:  thru_enable_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q          <= 1'b0;
			pieces_q          <= '0;
			start_frame_q     <= '0;
			start_second_q    <= '0;
			start_minute_q    <= '0;
			start_hour_q      <= '0;
			rate_q            <= RATE_24;
			frame_count_q     <= '0;
			last_frame_time_q <= '0;
		end else if (cmd.decode && is_qf) begin
			if (locked_q) begin
				// pieces 0 and 4 mark a new frame
				if (piece[1:0] == 2'd0) begin
					last_frame_time_q <= TIME_BITS'(item_q.now_ms);
					frame_count_q     <= frame_count_q + 32'd1;
				end
			end else begin
				// the piece set starts over after every last piece
				pieces_q <= (piece == PIECE_LAST) ? 8'b0 : seen_next;
				case (piece)
					3'd0: begin
						last_frame_time_q <= TIME_BITS'(item_q.now_ms);
						start_frame_q     <= {4'b0, nib};
					end
					3'd1: start_frame_q  <= start_frame_q | {nib, 4'b0};
					3'd2: start_second_q <= {4'b0, nib};
					3'd3: start_second_q <= start_second_q | {nib, 4'b0};
					3'd4: start_minute_q <= {4'b0, nib};
					3'd5: start_minute_q <= start_minute_q | {nib, 4'b0};
					3'd6: start_hour_q   <= {1'b0, nib};
					default: begin
						start_hour_q <= start_hour_q | {item_q.msg_data1[0], 4'b0};
						rate_q       <= item_q.msg_data1[2:1];
						if (seen_next == ALL_PIECES) begin
							last_frame_time_q <= TIME_BITS'(item_q.now_ms);
							locked_q          <= 1'b1;
						end
					end
				endcase
			end
		end else if (cmd.lock3) begin
			frame_count_q <= 32'(22'(acc_q) * 22'(fps) + 22'(start_frame_q));
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.decode) begin
			rec_chan_q <= sts.rec_chan;
			mark_q     <= sts.lock_now;
			thru_q     <= is_other && thru_enable_q;
		end
		if (cmd.lock1) begin
			acc_q <= 17'(17'(start_hour_q) * 17'(SIXTY) + 17'(start_minute_q));
		end
		if (cmd.lock2) begin
			acc_q <= 17'(acc_q * 17'(SIXTY) + 17'(start_second_q));
		end
		if (cmd.div_load) begin
			div_q     <= frame_count_q;
			div_rem_q <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			// restoring divide, one quotient bit per cycle
			div_q     <= {div_q[30:0], trial_ge};
			div_rem_q <= trial_ge ? 5'(trial - {1'b0, fps}) : trial[4:0];
			div_cnt_q <= div_cnt_q + 5'd1;
		end
		if (cmd.part_mul) begin
			prod_q  <= 22'(div_rem_q) * 22'(us_per_frame_q);
			whole_q <= 42'(div_q) * 42'(MS_PER_S);
		end
		if (cmd.part_div) begin
			part_q <= recip_prod[44:32];
		end
		if (cmd.time_sum) begin
			time_q <= TIME_BITS'(whole_q) + TIME_BITS'(part_q)
				+ (rec_chan_q ? elapsed : '0);
		end
		if (cmd.out_load) begin
			result_q.rec_valid  <= rec_chan_q || mark_q;
			result_q.thru_valid <= thru_q;
			if (mark_q) begin
				result_q.rec_message <= {16'b0, ST_QUARTER_FRAME};
			end else if (rec_chan_q) begin
				result_q.rec_message <= {item_q.msg_data2, item_q.msg_data1,
					item_q.msg_status};
			end else begin
				result_q.rec_message <= '0;
			end
			result_q.rec_time <= (rec_chan_q || mark_q) ? 32'(time_q) : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/mtc_quarter_frame_decoder_core.sv =====
// Top level: MIDI time code quarter-frame decoder with time-stamped recording.
// Messages that record nothing go from decode straight to the output stage; a
// recorded channel message runs divider load, frame/fps divide, part multiply,
// part divide and time sum; the lock mark runs the lock steps first. One item at
// a time; a finished result waits in the output register while the next is taken.
// Reset: arst_n clears lock, piece set, start fields and frame count; registers
// return to us_per_frame 41667 and thru off. No clearing pass.
module mtc_quarter_frame_decoder_core #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  mtcqf_pkg::mtc_item_t             item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output mtcqf_pkg::mtc_result_t           result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mtcqf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mtcqf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mtcqf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	mtcqf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mtcqf_datapath #(
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule
